[rtl/sorted_alarm_table_advance_defines.svh]
// Assertion macros shared by the alarm table RTL.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef SORTED_ALARM_TABLE_ADVANCE_DEFINES_SVH
`define SORTED_ALARM_TABLE_ADVANCE_DEFINES_SVH

// Check on every rising edge outside reset.
`define SAT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Check on every rising edge, reset included.
`define SAT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error(msg);

`endif

[rtl/sat_pkg.sv]
// Types and constants of the sorted alarm table.
// Used by sat_ctrl, sat_dp and the top level; depends on nothing.
package sat_pkg;

  localparam int unsigned TimeW = 64;
  localparam int unsigned IdInW = 8;

  typedef enum logic [1:0] {
    FUNC_ADD = 2'd0,
    FUNC_SET = 2'd1,
    FUNC_ADV = 2'd2
  } func_e;

  localparam logic STATUS_FIRED  = 1'b0;
  localparam logic STATUS_REJECT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_ADD_SCAN,
    ST_ADD_PLACE,
    ST_ADV_SCAN,
    ST_ADV_FLUSH,
    ST_REJECT
  } state_e;

  typedef struct packed {
    logic accept;
    logic set_now;
    logic add_start;
    logic add_shift;
    logic add_place;
    logic adv_start;
    logic adv_step;
    logic out_flush;
    logic out_reject;
  } cmd_t;

  typedef struct packed {
    func_e func;
    logic  full;
    logic  empty;
    logic  target_ahead;
    logic  rd_later;
    logic  shift_last;
    logic  scan_hit;
    logic  scan_end;
    logic  pend_valid;
    logic  out_free;
  } status_t;

endpackage

[rtl/sorted_alarm_table_advance.sv]
// Sorted alarm table: keeps a current time and up to TABLE_DEPTH alarms ordered by
// trigger time (equal times in insertion order). An add item (tuser 0) inserts an
// alarm, or returns one reject result (tuser 1, tlast 1) when the table is full; a
// set item (tuser 1) loads the current time; an advance item (tuser 2) to a target
// later than the current time streams out, in time order, every alarm in
// (current, target], tlast on the final one, and moves the current time to the
// target when the update flag is set. Alarms are never removed. One item at a time
// is handled. The table sits in a memory with one read and one write port and is
// walked one entry per cycle, except while an advance waits on the output side.
// Results leave through an output register, so the last result of an item may
// still wait while the next item is taken. No clearing pass follows reset.
// Depends on sat_pkg, sat_ctrl and sat_dp.

module sorted_alarm_table_advance
  import sat_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 16,
  parameter int unsigned ID_BITS     = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream.
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [79:0] s_axis_tdata_i,  // [7:0] alarm_id, [71:8] time_value,
                                       // [72] update_time, [79:73] zero
  input  logic [1:0]  s_axis_tuser_i,  // [1:0] func
  // Result stream.
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [71:0] m_axis_tdata_o,  // [7:0] fired_id, [71:8] fired_time
  output logic [0:0]  m_axis_tuser_o,  // [0] status
  output logic        m_axis_tlast_o
);

  cmd_t    cmd;
  status_t st;

  logic [IdInW-1:0] out_id;
  logic [TimeW-1:0] out_time;
  logic             out_status;

  // Sequence the item: decode, table walk, result hand-off.
  sat_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  // Table memory, current time and output register.
  sat_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .ID_BITS     (ID_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .st_o         (st),
    .in_func_i    (s_axis_tuser_i),
    .in_id_i      (s_axis_tdata_i[7:0]),
    .in_time_i    (s_axis_tdata_i[71:8]),
    .in_update_i  (s_axis_tdata_i[72]),
    .out_ready_i  (m_axis_tready_i),
    .out_valid_o  (m_axis_tvalid_o),
    .out_status_o (out_status),
    .out_id_o     (out_id),
    .out_time_o   (out_time),
    .out_last_o   (m_axis_tlast_o)
  );

  // Pack the result transfer.
  assign m_axis_tdata_o = {out_time, out_id};
  assign m_axis_tuser_o = out_status;

endmodule

[rtl/sat_ctrl.sv]
// Sequencer of the sorted alarm table: decodes an item and steps the table walk.
// Depends on sat_pkg and the assertion macros header.
`include "sorted_alarm_table_advance_defines.svh"

module sat_ctrl
  import sat_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t st_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  logic scan_stall;
  assign scan_stall = st_i.scan_hit && st_i.pend_valid && !st_i.out_free;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DECODE;
      end
      ST_DECODE: begin
        unique case (st_i.func)
          FUNC_ADD: begin
            if (st_i.full) state_d = ST_REJECT;
            else if (st_i.empty) state_d = ST_ADD_PLACE;
            else state_d = ST_ADD_SCAN;
          end
          FUNC_ADV: begin
            if (st_i.target_ahead && !st_i.empty) state_d = ST_ADV_SCAN;
            else state_d = ST_IDLE;
          end
          default: state_d = ST_IDLE;
        endcase
      end
      ST_ADD_SCAN: begin
        if (!st_i.rd_later) state_d = ST_IDLE;
        else if (st_i.shift_last) state_d = ST_ADD_PLACE;
      end
      ST_ADD_PLACE: state_d = ST_IDLE;
      ST_ADV_SCAN: begin
        if (!scan_stall && st_i.scan_end) begin
          state_d = (st_i.scan_hit || st_i.pend_valid) ? ST_ADV_FLUSH : ST_IDLE;
        end
      end
      ST_ADV_FLUSH: begin
        if (st_i.out_free) state_d = ST_IDLE;
      end
      ST_REJECT: begin
        if (st_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      ST_DECODE: begin
        unique case (st_i.func)
          FUNC_ADD: cmd_o.add_start = !st_i.full;
          FUNC_SET: cmd_o.set_now   = 1'b1;
          FUNC_ADV: cmd_o.adv_start = st_i.target_ahead;
          default: ;
        endcase
      end
      ST_ADD_SCAN: begin
        cmd_o.add_shift = st_i.rd_later;
        cmd_o.add_place = !st_i.rd_later;
      end
      ST_ADD_PLACE: cmd_o.add_place = 1'b1;
      ST_ADV_SCAN:  cmd_o.adv_step  = !scan_stall;
      ST_ADV_FLUSH: cmd_o.out_flush = st_i.out_free;
      ST_REJECT:    cmd_o.out_reject = st_i.out_free;
      default: ;
    endcase
  end

  `SAT_ASSERT(a_cmd_exclusive, $onehot0(cmd_o), "datapath commands overlap")
  `SAT_ASSERT(a_decode_follows_transfer,
              (state_q == ST_DECODE) |-> $past(in_valid_i && in_ready_o),
              "decode entered without an input transfer")
  `SAT_ASSERT(a_scan_stall_holds,
              (state_q == ST_ADV_SCAN && scan_stall) |=> (state_q == ST_ADV_SCAN),
              "scan left while a fired alarm was still waiting")

endmodule

[rtl/sat_dp.sv]
// Datapath of the sorted alarm table: item registers, current time, table memory,
// pending fired alarm and the output register. Depends on sat_pkg and the macros header.
`include "sorted_alarm_table_advance_defines.svh"

module sat_dp
  import sat_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 16,
  parameter int unsigned ID_BITS     = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cmd_t             cmd_i,
  output status_t          st_o,
  input  logic [1:0]       in_func_i,
  input  logic [IdInW-1:0] in_id_i,
  input  logic [TimeW-1:0] in_time_i,
  input  logic             in_update_i,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output logic             out_status_o,
  output logic [IdInW-1:0] out_id_o,
  output logic [TimeW-1:0] out_time_o,
  output logic             out_last_o
);

  localparam int unsigned IdW   = (ID_BITS < IdInW) ? ID_BITS : IdInW;
  localparam int unsigned CntW  = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned AddrW = $clog2(TABLE_DEPTH);

  // Item registers.
  logic [1:0]       item_func_q;
  logic [IdW-1:0]   item_id_q;
  logic [TimeW-1:0] item_time_q;
  logic             item_update_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      item_func_q   <= in_func_i;
      item_id_q     <= in_id_i[IdW-1:0];
      item_time_q   <= in_time_i;
      item_update_q <= in_update_i;
    end
  end

  logic [TimeW-1:0] now_q, cur_q;
  logic [CntW-1:0]  count_q, idx_q;
  logic             pend_valid_q, out_valid_q;
  logic [IdW-1:0]   pend_id_q, rd_id_q;
  logic [TimeW-1:0] pend_time_q, rd_time_q;

  // Table memory, one read and one write port.
  logic [TimeW-1:0] mem_time [TABLE_DEPTH];
  logic [IdW-1:0]   mem_id   [TABLE_DEPTH];

  logic             rd_en;
  logic [CntW-1:0]  rd_addr;
  logic             wr_en;

  // Status toward the controller.
  logic rd_over, scan_hit, scan_end, out_free;
  assign rd_over  = rd_time_q > item_time_q;
  assign scan_hit = !rd_over && (rd_time_q > cur_q);
  assign scan_end = rd_over || (idx_q == count_q - CntW'(1));
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    st_o.func         = func_e'(item_func_q);
    st_o.full         = count_q == CntW'(TABLE_DEPTH);
    st_o.empty        = count_q == '0;
    st_o.target_ahead = item_time_q > now_q;
    st_o.rd_later     = rd_over;
    st_o.shift_last   = idx_q == CntW'(1);
    st_o.scan_hit     = scan_hit;
    st_o.scan_end     = scan_end;
    st_o.pend_valid   = pend_valid_q;
    st_o.out_free     = out_free;
  end

  // Read address: walk down for an insertion, up for an advance.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    if (cmd_i.add_start) begin
      rd_en   = count_q != '0;
      rd_addr = count_q - CntW'(1);
    end else if (cmd_i.add_shift) begin
      rd_en   = idx_q != CntW'(1);
      rd_addr = idx_q - CntW'(2);
    end else if (cmd_i.adv_start) begin
      rd_en   = 1'b1;
      rd_addr = '0;
    end else if (cmd_i.adv_step) begin
      rd_en   = !scan_end;
      rd_addr = idx_q + CntW'(1);
    end
  end

  assign wr_en = cmd_i.add_shift || cmd_i.add_place;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_time[idx_q[AddrW-1:0]] <= cmd_i.add_shift ? rd_time_q : item_time_q;
      mem_id[idx_q[AddrW-1:0]]   <= cmd_i.add_shift ? rd_id_q : item_id_q;
    end
    if (rd_en) begin
      rd_time_q <= mem_time[rd_addr[AddrW-1:0]];
      rd_id_q   <= mem_id[rd_addr[AddrW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q        <= '0;
      count_q      <= '0;
      idx_q        <= '0;
      pend_valid_q <= 1'b0;
    end else begin
      if (cmd_i.set_now || (cmd_i.adv_start && item_update_q)) now_q <= item_time_q;
      if (cmd_i.add_place) count_q <= count_q + CntW'(1);
      if (cmd_i.add_start) idx_q <= count_q;
      else if (cmd_i.add_shift) idx_q <= idx_q - CntW'(1);
      else if (cmd_i.adv_start) idx_q <= '0;
      else if (cmd_i.adv_step && !scan_end) idx_q <= idx_q + CntW'(1);
      if (cmd_i.adv_step && scan_hit) pend_valid_q <= 1'b1;
      else if (cmd_i.out_flush) pend_valid_q <= 1'b0;
    end
  end

  // Hold the time the advance started from, and the newest alarm in range.
  always_ff @(posedge clk_i) begin
    if (cmd_i.adv_start) cur_q <= now_q;
    if (cmd_i.adv_step && scan_hit) begin
      pend_time_q <= rd_time_q;
      pend_id_q   <= rd_id_q;
    end
  end

  // Output register.
  logic out_push_pend, out_load;
  assign out_push_pend = (cmd_i.adv_step && scan_hit && pend_valid_q) || cmd_i.out_flush;
  assign out_load      = out_push_pend || cmd_i.out_reject;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_push_pend) begin
      out_status_o <= STATUS_FIRED;
      out_id_o     <= IdInW'(pend_id_q);
      out_time_o   <= pend_time_q;
      out_last_o   <= cmd_i.out_flush;
    end else if (cmd_i.out_reject) begin
      out_status_o <= STATUS_REJECT;
      out_id_o     <= IdInW'(item_id_q);
      out_time_o   <= item_time_q;
      out_last_o   <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;

  `SAT_ASSERT(a_count_in_range, count_q <= CntW'(TABLE_DEPTH), "alarm count past table depth")
  `SAT_ASSERT(a_load_needs_slot, out_load |-> out_free,
              "output register loaded while still occupied")
  `SAT_ASSERT(a_count_only_on_place, !cmd_i.add_place |=> $stable(count_q),
              "alarm count moved without an insertion")
  `SAT_ASSERT_ALWAYS(a_no_output_in_reset, !rst_ni |=> !out_valid_q,
                     "output valid during reset")

endmodule

[test/testbench.sv]
// Self-checking bench for sorted_alarm_table_advance: drives add, set and advance
// transfers with random gaps and checks every result against a behavioral table model.
// Depends on sat_pkg and the sorted_alarm_table_advance RTL.
`timescale 1ns / 1ps

module testbench
  import sat_pkg::*;
();

  localparam int unsigned Depth       = 16;
  localparam int unsigned IdleRate    = 31;   // percent of cycles a side holds off
  localparam int unsigned RandomItems = 460;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned ReportLimit = 10;
  localparam int unsigned DrainCycles = 40;
  localparam logic [1:0]  FuncSpare   = 2'd3;  // unused code, block ignores it
  localparam logic [63:0] TimeMax     = '1;

  typedef struct packed {
    logic        status;
    logic [7:0]  id;
    logic [63:0] stamp;
    logic        last;
  } alarm_result_t;

  // Alarm table model plus the queue of results it still owes.
  class alarm_scoreboard;
    logic [63:0]   now_ns;
    logic [63:0]   slot_time [Depth];
    logic [7:0]    slot_id [Depth];
    int unsigned   fill;
    int unsigned   errors;
    alarm_result_t due [$];

    function new();
      now_ns = '0;
      fill   = 0;
      errors = 0;
    endfunction

    // Append one owed result at the tail of the queue.
    function void owe(alarm_result_t r);
      due.insert(due.size(), r);
    endfunction

    function void note_item(logic [1:0] func, logic [7:0] id, logic [63:0] value,
                            logic upd);
      alarm_result_t held;
      bit            have;
      int unsigned   pos;
      logic [63:0]   start;
      have = 0;
      case (func)
        FUNC_ADD: begin
          if (fill == Depth) begin
            held = '{STATUS_REJECT, id, value, 1'b1};
            owe(held);
          end else begin
            // Insert after every entry with an equal or earlier time.
            pos = 0;
            while (pos < fill && slot_time[pos] <= value) pos++;
            for (int i = fill; i > pos; i--) begin
              slot_time[i] = slot_time[i-1];
              slot_id[i]   = slot_id[i-1];
            end
            slot_time[pos] = value;
            slot_id[pos]   = id;
            fill++;
          end
        end
        FUNC_SET: now_ns = value;
        FUNC_ADV: begin
          if (value > now_ns) begin
            start = now_ns;
            if (upd) now_ns = value;
            for (int i = 0; i < fill && slot_time[i] <= value; i++) begin
              if (slot_time[i] > start) begin
                if (have) owe(held);
                held = '{STATUS_FIRED, slot_id[i], slot_time[i], 1'b0};
                have = 1;
              end
            end
            if (have) begin
              held.last = 1'b1;
              owe(held);
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void flag(string what, logic [63:0] want, logic [63:0] got);
      errors++;
      if (errors <= ReportLimit)
        $display("%0t: %s mismatch, expected %h, got %h", $realtime, what, want, got);
    endfunction

    function void check_result(alarm_result_t got);
      alarm_result_t want;
      if (due.size() == 0) begin
        errors++;
        if (errors <= ReportLimit)
          $display("%0t: unexpected result id %h time %h", $realtime, got.id, got.stamp);
      end else begin
        want = due.pop_front();
        if (got.status !== want.status) flag("status", want.status, got.status);
        if (got.id !== want.id) flag("fired_id", want.id, got.id);
        if (got.stamp !== want.stamp) flag("fired_time", want.stamp, got.stamp);
        if (got.last !== want.last) flag("last", want.last, got.last);
      end
    endfunction
  endclass

  logic        clk_i    = 1'b0;
  logic        rst_ni   = 1'b0;
  logic        s_tvalid = 1'b0;
  logic [79:0] s_tdata  = '0;
  logic [1:0]  s_tuser  = '0;
  logic        m_tready = 1'b0;
  logic        s_tready;
  logic        m_tvalid;
  logic [71:0] m_tdata;
  logic [0:0]  m_tuser;
  logic        m_tlast;
  bit          calm = 1'b0;   // high: neither side idles
  int unsigned cycles = 0;

  alarm_scoreboard ledger = new();

  sorted_alarm_table_advance uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Stall the result side at random, except in the calm window.
  always @(posedge clk_i) begin
    m_tready <= calm || ($urandom_range(0, 99) >= IdleRate);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid && m_tready)
      ledger.check_result('{m_tuser[0], m_tdata[7:0], m_tdata[71:8], m_tlast});
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("** sorted_alarm_table_advance: FAILED **");
      $finish;
    end
  end

  // Offer one item, idling at random first; leave tvalid high after the transfer.
  task automatic send_item(input logic [1:0] func, input logic [7:0] id,
                           input logic [63:0] value, input logic upd);
    while (!calm && $urandom_range(0, 99) < IdleRate) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {7'b0, upd, value, id};
    s_tuser  <= func;
    do @(posedge clk_i); while (!s_tready);
    ledger.note_item(func, id, value, upd);
  endtask

  // Hold the input side until every owed result has been taken.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk_i); while (ledger.due.size() != 0);
  endtask

  function automatic logic [63:0] any_time();
    return {$urandom, $urandom};
  endfunction

  initial begin
    int unsigned pick;
    int unsigned shape;
    logic [63:0] value;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Advance on an empty table, then a target equal to the current time.
    send_item(FUNC_ADV, 8'h00, 64'd10, 1'b0);
    send_item(FUNC_ADV, 8'h00, 64'd0, 1'b1);
    // Ties stay in insertion order; cover front, middle and end inserts.
    send_item(FUNC_ADD, 8'hA5, 64'd100, 1'b0);
    send_item(FUNC_ADD, 8'h5A, 64'd100, 1'b0);
    send_item(FUNC_ADD, 8'h00, 64'd0, 1'b0);
    send_item(FUNC_ADD, 8'hFF, TimeMax, 1'b0);
    send_item(FUNC_ADD, 8'h01, 64'd50, 1'b0);
    send_item(FUNC_ADV, 8'h00, 64'd100, 1'b0);
    // Fill the table with a cluster of times so ties land mid-table.
    repeat (Depth - 5)
      send_item(FUNC_ADD, 8'($urandom_range(0, 255)), 64'($urandom_range(200, 260)), 1'b0);
    // Full table rejects the add.
    send_item(FUNC_ADD, 8'h3C, 64'h8000_0000_0000_0001, 1'b1);
    // Target not past the current time: nothing fires, time stays.
    send_item(FUNC_SET, 8'h00, TimeMax, 1'b0);
    send_item(FUNC_ADV, 8'h00, TimeMax, 1'b1);
    // Sweep the whole range from zero: every alarm but the one at zero fires.
    send_item(FUNC_SET, 8'h00, 64'd0, 1'b0);
    send_item(FUNC_ADV, 8'h00, TimeMax, 1'b0);
    send_item(FuncSpare, 8'hC3, any_time(), 1'b1);
    // Empty window still moves the time; a repeat of the target then does nothing.
    send_item(FUNC_ADV, 8'h00, 64'd40, 1'b1);
    send_item(FUNC_ADV, 8'h00, 64'd60, 1'b1);
    send_item(FUNC_ADV, 8'h00, 64'd60, 1'b0);
    wait_drained();

    for (int n = 0; n < RandomItems; n++) begin
      if (n == 180) calm <= 1'b1;
      if (n == 260) calm <= 1'b0;
      if (n == 300) wait_drained();
      pick  = $urandom_range(0, 99);
      shape = $urandom_range(0, 99);
      if (pick < 25) begin
        value = (shape < 80) ? 64'($urandom_range(0, 1000)) : any_time();
        send_item(FUNC_SET, 8'($urandom_range(0, 255)), value, 1'($urandom_range(0, 1)));
      end else if (pick < 75) begin
        value = (shape < 85) ? 64'($urandom_range(0, 1200)) : any_time();
        send_item(FUNC_ADV, 8'($urandom_range(0, 255)), value, 1'($urandom_range(0, 1)));
      end else if (pick < 95) begin
        send_item(FUNC_ADD, 8'($urandom_range(0, 255)), any_time(), 1'($urandom_range(0, 1)));
      end else begin
        send_item(FuncSpare, 8'($urandom_range(0, 255)), any_time(),
                  1'($urandom_range(0, 1)));
      end
    end

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (ledger.errors == 0 && ledger.due.size() == 0) begin
      $display("** sorted_alarm_table_advance: PASSED **");
    end else begin
      $display("** sorted_alarm_table_advance: FAILED **");
    end
    $finish;
  end

endmodule
